// ===== rtl/core/rsst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsst_pkg: shared definitions for the range sum segment tree
// Tree geometry, field widths, item codes and the command/status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package rsst_pkg;

    // Tree geometry. The tree is padded up to a power of two of leaves.
    localparam int LEAVES     = 1024;
    localparam int LEAF_W     = $clog2(LEAVES);
    localparam int PAD_LEAVES = 1 << LEAF_W;
    localparam int NODES      = 2 * PAD_LEAVES;
    localparam int NODE_W     = LEAF_W + 1;
    // Query cursors must hold the node count itself.
    localparam int BOUND_W    = NODE_W + 1;

    // Item field widths.
    localparam int DATA_W  = 32;
    localparam int POS_W   = 10;
    localparam int RANGE_W = 11;

    typedef enum logic {
        KIND_SET   = 1'b0,
        KIND_QUERY = 1'b1
    } kind_t;

    // Controller to datapath.
    typedef struct packed {
        logic clr_wr;     // write zero to the next node of the clearing pass
        logic upd_start;  // capture leaf position and value
        logic upd_wr;     // write current node, read its sibling
        logic upd_add;    // add sibling, move to parent
        logic qry_start;  // capture and clamp the range bounds
        logic qry_rd;     // read boundary nodes of this level, step up
        logic qry_acc;    // accumulate the nodes read
        logic out_load;   // move the sum into the result register
    } rsst_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic clr_last;   // clearing pass is on its last node
        logic upd_root;   // current update node is the root
        logic qry_open;   // query cursors still enclose nodes
        logic pos_ok;     // offered write position lies inside the leaves
    } rsst_sts_t;

endpackage

// ===== rtl/core/rsst_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsst_datapath: tree memory, cursors and accumulator
// Holds the node memory with one write port and two registered read ports,
// the update and query cursors, the running sum and the result register.
// ----------------------------------------------------------------------------
module rsst_datapath
    import rsst_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  rsst_cmd_t                 cmd,
    output rsst_sts_t                 sts,
    input  logic [POS_W-1:0]          position,
    input  logic signed [DATA_W-1:0]  value,
    input  logic [RANGE_W-1:0]        range_low,
    input  logic [RANGE_W-1:0]        range_high,
    output logic signed [DATA_W-1:0]  range_total
);

    logic [DATA_W-1:0]  tree_mem [0:NODES-1];

    logic [NODE_W-1:0]  clr_idx_reg, clr_idx_next;
    logic [NODE_W-1:0]  node_reg, node_next;
    logic [BOUND_W-1:0] lo_reg, lo_next;
    logic [BOUND_W-1:0] hi_reg, hi_next;
    logic [DATA_W-1:0]  acc_reg, acc_next;
    logic               en_a_reg, en_a_next;
    logic               en_b_reg, en_b_next;
    logic [DATA_W-1:0]  rd_a_reg;
    logic [DATA_W-1:0]  rd_b_reg;
    logic [DATA_W-1:0]  total_reg, total_next;

    logic               mem_we;
    logic [NODE_W-1:0]  mem_waddr;
    logic [DATA_W-1:0]  mem_wdata;
    logic [NODE_W-1:0]  rd_a_addr;
    logic [BOUND_W-1:0] hi_dec;
    logic [RANGE_W-1:0] hi_lim;
    logic [DATA_W-1:0]  add_a;
    logic [DATA_W-1:0]  add_b;

    // A high bound beyond the leaves is limited to the leaf count.
    assign hi_lim = (range_high > RANGE_W'(LEAVES)) ? RANGE_W'(LEAVES) : range_high;
    assign hi_dec = hi_reg - BOUND_W'(1);

    assign mem_we    = cmd.clr_wr | cmd.upd_wr;
    assign mem_waddr = cmd.clr_wr ? clr_idx_reg : node_reg;
    assign mem_wdata = cmd.clr_wr ? '0 : acc_reg;
    assign rd_a_addr = cmd.upd_wr ? (node_reg ^ NODE_W'(1)) : lo_reg[NODE_W-1:0];

    assign add_a = en_a_reg ? rd_a_reg : '0;
    assign add_b = en_b_reg ? rd_b_reg : '0;

    always_comb
    begin
        clr_idx_next = clr_idx_reg;
        node_next    = node_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        acc_next     = acc_reg;
        en_a_next    = en_a_reg;
        en_b_next    = en_b_reg;
        total_next   = total_reg;

        if (cmd.clr_wr)
        begin
            clr_idx_next = clr_idx_reg + NODE_W'(1);
        end
        if (cmd.upd_start)
        begin
            node_next = NODE_W'(PAD_LEAVES) + NODE_W'(position);
            acc_next  = value;
        end
        if (cmd.upd_add)
        begin
            acc_next  = acc_reg + rd_a_reg;
            node_next = node_reg >> 1;
        end
        if (cmd.qry_start)
        begin
            lo_next  = BOUND_W'(PAD_LEAVES) + BOUND_W'(range_low);
            hi_next  = BOUND_W'(PAD_LEAVES) + BOUND_W'(hi_lim);
            acc_next = '0;
        end
        if (cmd.qry_rd)
        begin
            // An odd low cursor is a right child: take it and step past it.
            // An odd high cursor means its left neighbor is inside the range.
            en_a_next = lo_reg[0];
            en_b_next = hi_reg[0];
            lo_next   = (lo_reg >> 1) + BOUND_W'(lo_reg[0]);
            hi_next   = hi_reg >> 1;
        end
        if (cmd.qry_acc)
        begin
            acc_next = acc_reg + add_a + add_b;
        end
        if (cmd.out_load)
        begin
            total_next = acc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg <= '0;
        end
        else
        begin
            clr_idx_reg <= clr_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg  <= node_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        acc_reg   <= acc_next;
        en_a_reg  <= en_a_next;
        en_b_reg  <= en_b_next;
        total_reg <= total_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            tree_mem[mem_waddr] <= mem_wdata;
        end
        rd_a_reg <= tree_mem[rd_a_addr];
        rd_b_reg <= tree_mem[hi_dec[NODE_W-1:0]];
    end

    assign sts.clr_last = &clr_idx_reg;
    assign sts.upd_root = (node_reg == NODE_W'(1));
    assign sts.qry_open = (lo_reg < hi_reg);
    assign sts.pos_ok   = (NODE_W'(position) < NODE_W'(LEAVES));

    assign range_total = total_reg;

endmodule

// ===== rtl/core/rsst_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsst_ctrl: sequencing controller for the segment tree
// Runs the clearing pass after reset, walks the update path to the root,
// steps the query cursors level by level and hands out the result.
// ----------------------------------------------------------------------------
module rsst_ctrl
    import rsst_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  logic      kind,
    output logic      out_valid,
    input  logic      out_stall,
    input  rsst_sts_t sts,
    output rsst_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPD_WR,
        ST_UPD_ADD,
        ST_QRY_RD,
        ST_QRY_ACC,
        ST_QRY_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   in_xfer;
    logic   out_xfer;
    logic   out_free;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_xfer  = out_valid_reg && !out_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_xfer ? 1'b0 : out_valid_reg;
        cmd            = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (kind == KIND_QUERY)
                    begin
                        cmd.qry_start = 1'b1;
                        state_next    = ST_QRY_RD;
                    end
                    else if (sts.pos_ok)
                    begin
                        cmd.upd_start = 1'b1;
                        state_next    = ST_UPD_WR;
                    end
                end
            end
            ST_UPD_WR:
            begin
                cmd.upd_wr = 1'b1;
                state_next = sts.upd_root ? ST_IDLE : ST_UPD_ADD;
            end
            ST_UPD_ADD:
            begin
                cmd.upd_add = 1'b1;
                state_next  = ST_UPD_WR;
            end
            ST_QRY_RD:
            begin
                if (sts.qry_open)
                begin
                    cmd.qry_rd = 1'b1;
                    state_next = ST_QRY_ACC;
                end
                else
                begin
                    state_next = ST_QRY_OUT;
                end
            end
            ST_QRY_ACC:
            begin
                cmd.qry_acc = 1'b1;
                state_next  = ST_QRY_RD;
            end
            ST_QRY_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTH
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command in a cycle");

    a_result_from_query: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_QRY_OUT))
        else $error("result appeared without a finished query");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || !out_stall))
        else $error("result register loaded while a result is held");

    a_query_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && kind == KIND_QUERY) |=> (state_reg == ST_QRY_RD))
        else $error("accepted query did not start its walk");
`endif

endmodule

// ===== rtl/core/range_sum_segment_tree_unit.sv =====
`timescale 1ns / 1ps
// A write walks the path from its leaf up to the root, writing each node and
// adding its sibling, before the next item can be taken; a query reads and
// accumulates the boundary nodes level by level, then loads its result.
// Throughput: one item at a time; a stalled result holds the block in its last
// query cycle, so the next transfer also waits for the output side.
// Reset: a clearing pass zeroes all 2048 nodes, one per cycle, before the first
// input transfer is taken.
// ----------------------------------------------------------------------------
// range_sum_segment_tree_unit: point update, range sum segment tree
// Keeps a binary sum tree of signed 32-bit leaves in block memory; write items
// refresh the path to the root and query items return a wrapping range sum.
// ----------------------------------------------------------------------------
module range_sum_segment_tree_unit
    import rsst_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      kind,
    input  logic [POS_W-1:0]          position,
    input  logic signed [DATA_W-1:0]  value,
    input  logic [RANGE_W-1:0]        range_low,
    input  logic [RANGE_W-1:0]        range_high,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [DATA_W-1:0]  range_total
);

    rsst_cmd_t cmd;
    rsst_sts_t sts;

    rsst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    rsst_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .position    (position),
        .value       (value),
        .range_low   (range_low),
        .range_high  (range_high),
        .range_total (range_total)
    );

endmodule
